FILE: src/prle_pkg.sv
package prle_pkg;

   localparam int PALETTE_DEPTH_DEF = 16;

   localparam int COLOR_W     = 24;
   localparam int CHAN_W      = 8;
   localparam int SLOT_W      = 4;
   localparam int CODE_W      = 4;
   localparam int LEN_W       = 8;
   localparam int PSIZE_W     = 5;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   localparam logic [PSIZE_W-1:0] PSIZE_RESET   = PSIZE_W'(16);
   localparam logic [LEN_W-1:0]   MAX_RUN_RESET = LEN_W'(254);

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_PIXEL = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE_SIZE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RUN      = CSR_INDEX_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT
   } prle_state_type;

   typedef struct packed {
      logic               en;
      logic [SLOT_W-1:0]  slot;
      logic [COLOR_W-1:0] color;
   } palette_wr_type;

   typedef struct packed {
      logic               valid;
      logic [COLOR_W-1:0] color;
   } query_type;

endpackage

FILE: src/prle_if.sv
interface prle_req_if;
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic [prle_pkg::SLOT_W-1:0]  entry_index;
   logic [prle_pkg::CHAN_W-1:0]  red;
   logic [prle_pkg::CHAN_W-1:0]  green;
   logic [prle_pkg::CHAN_W-1:0]  blue;
   logic                         last_pixel;

   modport source (output valid, func, entry_index, red, green, blue, last_pixel,
                   input ready);
   modport sink   (input valid, func, entry_index, red, green, blue, last_pixel,
                   output ready);
endinterface

interface prle_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [prle_pkg::LEN_W-1:0]   run_length;
   logic [prle_pkg::CODE_W-1:0]  color_code;
   logic                         end_of_image;

   modport source (output valid, run_length, color_code, end_of_image, input ready);
   modport sink   (input valid, run_length, color_code, end_of_image, output ready);
endinterface

interface prle_csr_if;
   logic                              valid;
   logic                              ready;
   logic [prle_pkg::CSR_INDEX_W-1:0]  index;
   logic [prle_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/prle_cell.sv
module prle_cell #(
   parameter int CELL_INDEX = 0,
   parameter int CODE_WIDTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [prle_pkg::PSIZE_W-1:0]   palette_size,
   input  prle_pkg::palette_wr_type       wr,
   input  logic                           in_valid,
   input  logic [prle_pkg::COLOR_W-1:0]   in_color,
   input  logic                           in_found,
   input  logic [CODE_WIDTH-1:0]          in_code,
   output logic                           out_valid,
   output logic [prle_pkg::COLOR_W-1:0]   out_color,
   output logic                           out_found,
   output logic [CODE_WIDTH-1:0]          out_code
);
   import prle_pkg::*;

   localparam logic [CODE_WIDTH-1:0] MY_CODE = CODE_WIDTH'(CELL_INDEX);

   logic [COLOR_W-1:0]    entry_ff;
   logic                  valid_ff;
   logic [COLOR_W-1:0]    color_ff;
   logic                  found_ff;
   logic [CODE_WIDTH-1:0] code_ff;
   logic                  enabled;
   logic                  hit;

   // only the first palette_size cells take part in the search
   assign enabled = 32'(CELL_INDEX) < 32'(palette_size);
   assign hit     = in_valid && !in_found && enabled && (entry_ff == in_color);

   always_ff @(posedge clock) begin
      if (wr.en && (32'(wr.slot) == 32'(CELL_INDEX))) begin
         entry_ff <= wr.color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      color_ff <= in_color;
      found_ff <= in_found || hit;
      code_ff  <= hit ? MY_CODE : in_code;
   end

   assign out_valid = valid_ff;
   assign out_color = color_ff;
   assign out_found = found_ff;
   assign out_code  = code_ff;

endmodule

FILE: src/prle_ctrl.sv
module prle_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   prle_req_if.sink                      req_ch,
   prle_rsp_if.source                    rsp_ch,
   prle_csr_if.sink                      csr_ch,
   output prle_pkg::palette_wr_type      wr,
   output prle_pkg::query_type           query,
   output logic [prle_pkg::PSIZE_W-1:0]  palette_size,
   input  logic                          chain_valid,
   input  logic [prle_pkg::CODE_W-1:0]   chain_code
);
   import prle_pkg::*;

   prle_state_type     state_ff, state_in;
   logic               run_open_ff, run_open_in;
   logic [LEN_W-1:0]   run_count_ff, run_count_in;
   logic [COLOR_W-1:0] run_color_ff, run_color_in;
   logic               a_pend_ff, a_pend_in;
   logic [COLOR_W-1:0] a_color_ff, a_color_in;
   logic [LEN_W-1:0]   a_len_ff, a_len_in;
   logic               b_pend_ff, b_pend_in;
   logic [COLOR_W-1:0] b_color_ff, b_color_in;
   logic [LEN_W-1:0]   b_len_ff, b_len_in;
   logic [LEN_W-1:0]   cur_len_ff, cur_len_in;
   logic               cur_eoi_ff, cur_eoi_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic               out_valid_ff, out_valid_in;
   logic [PSIZE_W-1:0] psize_ff;
   logic [LEN_W-1:0]   max_run_ff;
   logic               req_take;
   logic [COLOR_W-1:0] pix_color;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign pix_color    = {req_ch.red, req_ch.green, req_ch.blue};

   assign wr.en    = req_take && (req_ch.func == FUNC_LOAD);
   assign wr.slot  = req_ch.entry_index;
   assign wr.color = pix_color;

   assign csr_ch.ready = 1'b1;
   assign palette_size = psize_ff;

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.run_length   = cur_len_ff;
   assign rsp_ch.color_code   = code_ff;
   assign rsp_ch.end_of_image = cur_eoi_ff;

   always_comb begin
      logic               emit_a;
      logic [COLOR_W-1:0] new_color;
      logic [LEN_W-1:0]   new_count;

      emit_a       = 1'b0;
      new_color    = run_color_ff;
      new_count    = run_count_ff;
      state_in     = state_ff;
      run_open_in  = run_open_ff;
      run_count_in = run_count_ff;
      run_color_in = run_color_ff;
      a_pend_in    = a_pend_ff;
      a_color_in   = a_color_ff;
      a_len_in     = a_len_ff;
      b_pend_in    = b_pend_ff;
      b_color_in   = b_color_ff;
      b_len_in     = b_len_ff;
      cur_len_in   = cur_len_ff;
      cur_eoi_in   = cur_eoi_ff;
      code_in      = code_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      query.valid  = 1'b0;
      query.color  = a_pend_ff ? a_color_ff : b_color_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_ch.func == FUNC_PIXEL)) begin
               if (!run_open_ff) begin
                  new_color = pix_color;
                  new_count = LEN_W'(1);
               end else if ((pix_color == run_color_ff) && (run_count_ff < max_run_ff)) begin
                  new_count = run_count_ff + LEN_W'(1);
               end else begin
                  emit_a    = 1'b1;
                  new_color = pix_color;
                  new_count = LEN_W'(1);
               end
               a_pend_in    = emit_a;
               a_color_in   = run_color_ff;
               a_len_in     = run_count_ff;
               run_color_in = new_color;
               b_color_in   = new_color;
               b_len_in     = new_count;
               b_pend_in    = req_ch.last_pixel;
               if (req_ch.last_pixel) begin
                  run_open_in  = 1'b0;
                  run_count_in = '0;
               end else begin
                  run_open_in  = 1'b1;
                  run_count_in = new_count;
               end
               if (emit_a || req_ch.last_pixel) begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            // launch only once the output register is free when the code lands
            if (!out_valid_ff || rsp_ch.ready) begin
               query.valid = 1'b1;
               state_in    = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (chain_valid) begin
               code_in      = chain_code;
               out_valid_in = 1'b1;
               if (a_pend_ff) begin
                  cur_len_in = a_len_ff;
                  cur_eoi_in = 1'b0;
                  a_pend_in  = 1'b0;
               end else begin
                  cur_len_in = b_len_ff;
                  cur_eoi_in = 1'b1;
                  b_pend_in  = 1'b0;
               end
               state_in = (a_pend_ff && b_pend_ff) ? ST_ISSUE : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_open_ff  <= 1'b0;
         run_count_ff <= '0;
         run_color_ff <= '0;
         a_pend_ff    <= 1'b0;
         b_pend_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_open_ff  <= run_open_in;
         run_count_ff <= run_count_in;
         run_color_ff <= run_color_in;
         a_pend_ff    <= a_pend_in;
         b_pend_ff    <= b_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_color_ff <= a_color_in;
      a_len_ff   <= a_len_in;
      b_color_ff <= b_color_in;
      b_len_ff   <= b_len_in;
      cur_len_ff <= cur_len_in;
      cur_eoi_ff <= cur_eoi_in;
      code_ff    <= code_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         psize_ff   <= PSIZE_RESET;
         max_run_ff <= MAX_RUN_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_PALETTE_SIZE: psize_ff   <= csr_ch.data[PSIZE_W-1:0];
            CSR_MAX_RUN:      max_run_ff <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

endmodule

FILE: src/palette_run_length_encoder_top.sv
// Channel   Dir  Word carries
// req_ch    in   func, entry_index, red, green, blue, last_pixel
// rsp_ch    out  run_length, color_code, end_of_image
// csr_ch    in   index (0 palette_size, 1 max_run), data
//
// A load word or a pixel word that closes no run leaves req_ch ready for the next
// word; each pair a word emits needs a lookup: the query is launched, passes
// through the row of PALETTE_DEPTH cells, then the code lands in the output register.
// Reset is synchronous, active high: no run open, registers at 16 and 254.
// A stall on rsp_ch holds the pair in the output register; req_ch keeps taking
// words until one closes a run, whose lookup waits until that register drains.
module palette_run_length_encoder_top #(
   parameter int PALETTE_DEPTH = prle_pkg::PALETTE_DEPTH_DEF
) (
   input logic         clock,
   input logic         reset,
   prle_req_if.sink    req_ch,
   prle_rsp_if.source  rsp_ch,
   prle_csr_if.sink    csr_ch
);
   import prle_pkg::*;

   localparam int IDX_W   = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   // code as it travels the row: wide enough for any cell index and the field
   localparam int CHAIN_W = (IDX_W > CODE_W) ? IDX_W : CODE_W;

   palette_wr_type     wr;
   query_type          query;
   logic [PSIZE_W-1:0] palette_size;

   // links between cells: link i feeds cell i, cell i drives link i + 1
   logic               link_valid [0:PALETTE_DEPTH];
   logic [COLOR_W-1:0] link_color [0:PALETTE_DEPTH];
   logic               link_found [0:PALETTE_DEPTH];
   logic [CHAIN_W-1:0] link_code  [0:PALETTE_DEPTH];

   // the controller holds run state and the registers, and sequences lookups
   prle_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_ch       (csr_ch),
      .wr           (wr),
      .query        (query),
      .palette_size (palette_size),
      .chain_valid  (link_valid[PALETTE_DEPTH]),
      .chain_code   (link_code[PALETTE_DEPTH][CODE_W-1:0])
   );

   // inject the query with no match yet; an unmatched colour leaves code 0
   assign link_valid[0] = query.valid;
   assign link_color[0] = query.color;
   assign link_found[0] = 1'b0;
   assign link_code[0]  = '0;

   // one cell per palette entry; the first match wins as the query moves down
   for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
      prle_cell #(
         .CELL_INDEX (i),
         .CODE_WIDTH (CHAIN_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .palette_size (palette_size),
         .wr           (wr),
         .in_valid     (link_valid[i]),
         .in_color     (link_color[i]),
         .in_found     (link_found[i]),
         .in_code      (link_code[i]),
         .out_valid    (link_valid[i+1]),
         .out_color    (link_color[i+1]),
         .out_found    (link_found[i+1]),
         .out_code     (link_code[i+1])
      );
   end

endmodule

FILE: verif/palette_run_length_encoder_top_tb.sv
`timescale 1ns / 100ps

module palette_run_length_encoder_top_tb;
   import prle_pkg::*;

   // One input word as the encoder sees it.
   typedef struct packed {
      logic              func;
      logic [SLOT_W-1:0] entry_index;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              last_pixel;
   } pixel_word_type;

   // One (run length, palette code) pair.
   typedef struct packed {
      logic [LEN_W-1:0]  run_length;
      logic [CODE_W-1:0] color_code;
      logic              end_of_image;
   } run_pair_type;

   logic clock = 1'b0;
   logic reset;

   prle_req_if req_ch ();
   prle_rsp_if rsp_ch ();
   prle_csr_if csr_ch ();

   palette_run_length_encoder_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // Encoder shadow: palette, open run and register copies.
   logic [COLOR_W-1:0] shadow_palette [PALETTE_DEPTH_DEF];
   logic [COLOR_W-1:0] run_color;
   logic [LEN_W-1:0]   run_count;
   logic               run_open;
   logic [PSIZE_W-1:0] search_size;
   logic [LEN_W-1:0]   run_limit;

   // Words waiting to be driven, and pairs the encoder still owes us.
   pixel_word_type word_queue [$];
   run_pair_type   pending_pairs [$];
   int             words_queued;
   int             words_taken;
   int             fail_count;

   // Idle control, set between phases by the stimulus process; the monitor marks the long hold done.
   int req_gap_max;
   int rsp_gap_max;
   bit long_hold_armed;
   bit long_hold_done;

   // Colors that the stimulus favors so that most runs hit the palette.
   logic [COLOR_W-1:0] hues [16];

   // Return the lowest searched palette slot holding this color, else 0.
   function automatic logic [CODE_W-1:0] palette_code(input logic [COLOR_W-1:0] color);
      int span;
      span = (search_size > PALETTE_DEPTH_DEF) ? PALETTE_DEPTH_DEF : int'(search_size);
      for (int i = 0; i < span; i++)
         if (shadow_palette[i] == color)
            return CODE_W'(i);
      return '0;
   endfunction

   // Advance the shadow by one accepted word; queue any pairs it closes.
   function automatic void encode_word(input pixel_word_type w);
      logic [COLOR_W-1:0] color;
      run_pair_type       pair;
      color = {w.red, w.green, w.blue};
      if (w.func == FUNC_LOAD) begin
         shadow_palette[w.entry_index] = color;
         return;
      end
      if (!run_open) begin
         run_open  = 1'b1;
         run_color = color;
         run_count = LEN_W'(1);
      end else if (color == run_color && run_count < run_limit) begin
         run_count = run_count + 1'b1;
      end else begin
         pair.run_length   = run_count;
         pair.color_code   = palette_code(run_color);
         pair.end_of_image = 1'b0;
         pending_pairs = {pending_pairs, pair};
         run_color = color;
         run_count = LEN_W'(1);
      end
      if (w.last_pixel) begin
         pair.run_length   = run_count;
         pair.color_code   = palette_code(run_color);
         pair.end_of_image = 1'b1;
         pending_pairs = {pending_pairs, pair};
         run_open  = 1'b0;
         run_count = '0;
      end
   endfunction

   // Favor palette colors; now and then throw in an arbitrary one.
   function automatic logic [COLOR_W-1:0] pick_color();
      if ($urandom_range(0, 3) != 0)
         return hues[$urandom_range(0, 15)];
      return COLOR_W'($urandom);
   endfunction

   // Driver: hold the word until taken, then idle for a drawn number of cycles.
   pixel_word_type held_word;
   int             req_gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap_left = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            encode_word(held_word);
            words_taken++;
            req_gap_left = $urandom_range(0, req_gap_max);
         end
         // A word still waiting for ready stays on the bus untouched.
         if (!(req_ch.valid && !req_ch.ready)) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_ch.valid <= 1'b0;
            end else if (word_queue.size() > 0) begin
               held_word = word_queue.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.func        <= held_word.func;
               req_ch.entry_index <= held_word.entry_index;
               req_ch.red         <= held_word.red;
               req_ch.green       <= held_word.green;
               req_ch.blue        <= held_word.blue;
               req_ch.last_pixel  <= held_word.last_pixel;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check every taken pair against the oldest one owed, then
   // stall ready at random; once, hold it off long enough to back up req_ch.
   run_pair_type got_pair;
   run_pair_type want_pair;
   int           rsp_stall_left;
   int           rsp_hold_left;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall_left = 0;
         rsp_hold_left  = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_pair.run_length   = rsp_ch.run_length;
            got_pair.color_code   = rsp_ch.color_code;
            got_pair.end_of_image = rsp_ch.end_of_image;
            if (pending_pairs.size() == 0) begin
               $display("%0t: unexpected pair: expected none, got len %0d code %0d eoi %0b",
                        $time, got_pair.run_length, got_pair.color_code,
                        got_pair.end_of_image);
               fail_count++;
            end else begin
               want_pair = pending_pairs.pop_front();
               if (got_pair !== want_pair) begin
                  $display("%0t: expected len %0d code %0d eoi %0b, got %0d %0d %0b",
                           $time, want_pair.run_length, want_pair.color_code,
                           want_pair.end_of_image, got_pair.run_length,
                           got_pair.color_code, got_pair.end_of_image);
                  fail_count++;
               end
            end
            rsp_stall_left = $urandom_range(0, rsp_gap_max);
            if (long_hold_armed && !long_hold_done) begin
               rsp_hold_left  = 400;
               long_hold_done = 1'b1;
            end
         end else if (rsp_hold_left > 0) begin
            rsp_hold_left--;
         end else if (rsp_stall_left > 0) begin
            rsp_stall_left--;
         end
         rsp_ch.ready <= (rsp_stall_left == 0 && rsp_hold_left == 0);
      end
   end

   task automatic queue_word(input logic func, input logic [SLOT_W-1:0] slot,
                             input logic [COLOR_W-1:0] color, input logic last);
      pixel_word_type w;
      w.func        = func;
      w.entry_index = slot;
      {w.red, w.green, w.blue} = color;
      w.last_pixel  = last;
      word_queue = {word_queue, w};
      words_queued++;
   endtask

   // Write one register and update the shadow copy on the handshake.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_PALETTE_SIZE)
         search_size = val[PSIZE_W-1:0];
      else if (idx == CSR_MAX_RUN)
         run_limit = val;
   endtask

   task automatic start_phase(input int psize, input int max_len,
                              input int req_gap, input int rsp_gap);
      write_reg(CSR_PALETTE_SIZE, CSR_DATA_W'(psize));
      write_reg(CSR_MAX_RUN, CSR_DATA_W'(max_len));
      req_gap_max = req_gap;
      rsp_gap_max = rsp_gap;
   endtask

   // Queue runs of equal pixels with random colors and lengths; sprinkle in
   // palette loads and stray end-of-image marks. long_max bounds the odd
   // long run that tests the forced break.
   task automatic queue_stream(input int count, input int long_max);
      int                 made;
      int                 len;
      bit                 image_end;
      logic [COLOR_W-1:0] color;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 19) == 0) begin
            queue_word(FUNC_LOAD, SLOT_W'($urandom), pick_color(), 1'($urandom));
            made++;
         end else begin
            color     = pick_color();
            len       = ($urandom_range(0, 15) == 0) ? $urandom_range(1, long_max)
                                                     : $urandom_range(1, 6);
            image_end = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < len; k++) begin
               queue_word(FUNC_PIXEL, SLOT_W'($urandom), color,
                          (image_end && k == len - 1) || ($urandom_range(0, 63) == 0));
               made++;
            end
         end
      end
   endtask

   // Wait until every word is taken and every pair is back, then give a
   // load word still in flight time to land before the next register write.
   task automatic wait_idle();
      do @(posedge clock);
      while (words_taken != words_queued || pending_pairs.size() != 0);
      repeat (64) @(posedge clock);
   endtask

   initial begin
      logic [COLOR_W-1:0] odd_color;

      // Drive every input to a known value before the first edge.
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.func        = FUNC_LOAD;
      req_ch.entry_index = '0;
      req_ch.red         = '0;
      req_ch.green       = '0;
      req_ch.blue        = '0;
      req_ch.last_pixel  = 1'b0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = CSR_PALETTE_SIZE;
      csr_ch.data        = '0;

      run_color   = '0;
      run_count   = '0;
      run_open    = 1'b0;
      search_size = PSIZE_RESET;
      run_limit   = MAX_RUN_RESET;
      foreach (shadow_palette[i])
         shadow_palette[i] = '0;
      words_queued    = 0;
      words_taken     = 0;
      fail_count      = 0;
      req_gap_max     = 4;
      rsp_gap_max     = 4;
      long_hold_armed = 1'b0;
      long_hold_done  = 1'b0;

      // Black and white at the ends; slot 9 repeats slot 4 so the lower
      // slot must win the match.
      foreach (hues[i])
         hues[i] = COLOR_W'($urandom);
      hues[0]  = '0;
      hues[15] = '1;
      hues[9]  = hues[4];
      odd_color = COLOR_W'($urandom);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset register values. Fill every palette slot first
      // so no lookup ever touches an unwritten entry; the load into slot 15
      // carries a last_pixel mark that must be ignored.
      for (int i = 0; i < 16; i++)
         queue_word(FUNC_LOAD, SLOT_W'(i), hues[i], i == 15);
      // Single-pixel image: white, the highest code.
      queue_word(FUNC_PIXEL, '0, hues[15], 1'b1);
      // Run of three on the duplicated color, then a last pixel that
      // differs: two pairs from one word.
      queue_word(FUNC_PIXEL, '1, hues[9], 1'b0);
      queue_word(FUNC_PIXEL, '0, hues[9], 1'b0);
      queue_word(FUNC_PIXEL, '1, hues[9], 1'b0);
      queue_word(FUNC_PIXEL, '0, hues[2], 1'b1);
      // Color likely off the palette: code falls back to zero.
      queue_word(FUNC_PIXEL, '0, odd_color, 1'b0);
      queue_word(FUNC_PIXEL, '1, odd_color, 1'b1);
      // Black then another color, closed by the last pixel.
      queue_word(FUNC_PIXEL, '0, hues[0], 1'b0);
      queue_word(FUNC_PIXEL, '1, hues[7], 1'b1);
      wait_idle();

      // Nothing searched, no run ever extended; heavy idling on both sides.
      start_phase(0, 0, 18, 18);
      queue_stream(70, 8);
      wait_idle();

      // One slot searched, runs of one; no idling at all.
      start_phase(1, 1, 0, 0);
      queue_stream(70, 8);
      wait_idle();

      // Size above the palette depth and the longest run; force a break at 255.
      start_phase(31, 255, 5, 0);
      for (int k = 0; k < 260; k++)
         queue_word(FUNC_PIXEL, SLOT_W'(k), hues[3], k == 259);
      queue_stream(60, 300);
      wait_idle();

      // Reset-like values again, written explicitly; force a break at 254.
      start_phase(16, 254, 0, 18);
      for (int k = 0; k < 256; k++)
         queue_word(FUNC_PIXEL, SLOT_W'(k), hues[15], k == 255);
      queue_stream(50, 300);
      wait_idle();

      // Short runs with a long receiver hold-off while words keep coming.
      long_hold_armed = 1'b1;
      start_phase(8, 3, 2, 3);
      queue_stream(100, 12);
      wait_idle();

      start_phase(5, 17, 18, 6);
      queue_stream(70, 40);
      wait_idle();

      start_phase(12, 254, 9, 9);
      queue_stream(50, 300);
      wait_idle();

      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Watchdog: several times the slowest legal run.
   initial begin
      #7_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: sim.f
src/prle_pkg.sv
src/prle_if.sv
src/prle_cell.sv
src/prle_ctrl.sv
src/palette_run_length_encoder_top.sv
verif/palette_run_length_encoder_top_tb.sv
